// ===== rtl/core/fmoc_pkg.sv =====
// Shared constants for the finger motor open/close controller.
// No dependencies.
package fmoc_pkg;

  // Phase codes
  localparam logic [1:0] PH_OPEN  = 2'd0;
  localparam logic [1:0] PH_CLOSE = 2'd1;
  localparam logic [1:0] PH_WAITO = 2'd2;
  localparam logic [1:0] PH_WAITC = 2'd3;

  // Word kinds carried on the input tuser
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_CMD    = 2'd2;

  // Register indexes (paddr[2])
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_TIME_MODE = 1'b1;

  // Port widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 16;

  localparam logic signed [DATA_W-1:0] S16_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] S16_MIN = -16'sh8000;

endpackage

// ===== rtl/core/finger_motor_open_close_fsm.sv =====
// H-bridge open/close controller for one finger, with current averaging window.
// Depends on fmoc_pkg.
//
// Each accepted input word yields its result word in the next cycle.
// Throughput: one word per cycle; input ready follows the output register
// (ready when it is empty or being drained).
// Reset (rst_ni low, asynchronous): phase open, both lines low, elapsed and
// open limit zero, window reads as all zeros via per-entry valid bits,
// threshold zero, mean mode. No clearing pass is needed.
module finger_motor_open_close_fsm #(
  parameter int unsigned WINDOW_SIZE = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] close_request, [16:1] offset, [32:17] sample, [39:33] zero
  input  logic [fmoc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] mode
  input  logic [fmoc_pkg::IN_USER_W-1:0]     s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] drive_close_line, [1] drive_open_line, [3:2] phase,
  // [19:4] elapsed, [23:20] zero
  output logic [fmoc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fmoc_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import fmoc_pkg::*;

  localparam int unsigned PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned SUM_W = DATA_W + $clog2(WINDOW_SIZE);
  // compare width: holds sum and threshold*N products with sign
  localparam int unsigned CMP_W = DATA_W + 1 + $clog2(WINDOW_SIZE + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_SIZE - 1);

  // ---------------- configuration ----------------
  logic signed [DATA_W-1:0] thr_q;
  logic                     time_mode_q;
  // mean < thr  <=>  sum < thr*N            (sum >= 0, floor)
  //             <=>  sum <= (thr-1)*N       (sum <  0, ceil)
  logic signed [CMP_W-1:0]  thr_n_q, thr_m1_n_q;
  logic signed [CMP_W-1:0]  wr_thr_ext, win_n, wr_thr_n, wr_thr_m1_n;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  assign wr_thr_ext  = CMP_W'($signed(pwdata[DATA_W-1:0]));
  assign win_n       = CMP_W'(WINDOW_SIZE);
  assign wr_thr_n    = wr_thr_ext * win_n;
  assign wr_thr_m1_n = (wr_thr_ext - CMP_W'(1)) * win_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      thr_n_q     <= '0;
      thr_m1_n_q  <= -win_n;
      time_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_THRESHOLD: begin
          thr_q      <= $signed(pwdata[DATA_W-1:0]);
          thr_n_q    <= wr_thr_n;
          thr_m1_n_q <= wr_thr_m1_n;
        end
        REG_TIME_MODE: time_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {16'd0, thr_q};
      REG_TIME_MODE: prdata = {31'd0, time_mode_q};
      default: prdata = '0;
    endcase
  end

  // ---------------- input unpack ----------------
  logic                     in_acc;
  logic [1:0]               in_mode;
  logic                     in_close;
  logic signed [DATA_W-1:0] in_off, in_smp;

  assign in_mode  = s_axis_tuser;
  assign in_close = s_axis_tdata[0];
  assign in_off   = $signed(s_axis_tdata[16:1]);
  assign in_smp   = $signed(s_axis_tdata[32:17]);

  // output register: ready while empty or being drained
  logic out_valid_q;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // ---------------- sample window ----------------
  logic signed [DATA_W-1:0] win_mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0]   win_vld_q;
  logic [PTR_W-1:0]         ptr_q, ptr_nxt;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  // prefetched oldest entry (the one at ptr_q)
  logic signed [DATA_W-1:0] rd_q, byp_q, oldest;
  logic                     rd_vld_q, byp_sel_q;
  logic                     smp_wr;

  assign smp_wr  = in_acc & (in_mode == MODE_SAMPLE);
  assign ptr_nxt = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
  assign oldest  = byp_sel_q ? byp_q : (rd_vld_q ? rd_q : '0);
  assign sum_d   = sum_q - SUM_W'(oldest) + SUM_W'(in_smp);

  always_ff @(posedge clk_i) begin
    if (smp_wr) begin
      win_mem[ptr_q] <= in_smp;
      rd_q           <= win_mem[ptr_nxt];
      byp_q          <= in_smp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
      ptr_q     <= '0;
      sum_q     <= '0;
      rd_vld_q  <= 1'b0;
      byp_sel_q <= 1'b0;
    end else if (smp_wr) begin
      win_vld_q[ptr_q] <= 1'b1;
      ptr_q            <= ptr_nxt;
      sum_q            <= sum_d;
      rd_vld_q         <= win_vld_q[ptr_nxt];
      // single-entry window: next read hits the word just written
      byp_sel_q        <= (ptr_nxt == ptr_q);
    end
  end

  // ---------------- phase / elapsed ----------------
  logic [1:0]               phase_q, phase_d;
  logic [1:0]               lines_q, lines_d;   // [0] close, [1] open
  logic signed [DATA_W-1:0] elapsed_q, elapsed_d;
  logic signed [DATA_W-1:0] limit_q, limit_d;
  logic signed [CMP_W-1:0]  sum_ext;
  logic                     mean_below, keep_closing;
  logic signed [DATA_W-1:0] el_quarter, open_lim;
  logic signed [DATA_W:0]   lim_sum;

  assign sum_ext      = CMP_W'(sum_q);
  assign mean_below   = sum_ext[CMP_W-1] ? (sum_ext <= thr_m1_n_q) : (sum_ext < thr_n_q);
  assign keep_closing = time_mode_q ? (elapsed_q < limit_q) : mean_below;

  // elapsed/4 truncated toward zero
  assign el_quarter = (elapsed_q + (elapsed_q[DATA_W-1] ? DATA_W'(3) : DATA_W'(0))) >>> 2;
  assign lim_sum    = (DATA_W+1)'(el_quarter) + (DATA_W+1)'(in_off);
  assign open_lim   = time_mode_q ? in_off : limit_q;

  always_comb begin
    phase_d   = phase_q;
    lines_d   = lines_q;
    elapsed_d = elapsed_q;
    limit_d   = limit_q;
    case (in_mode)
      MODE_TICK: begin
        unique case (phase_q)
          PH_OPEN:  if (elapsed_q != S16_MIN) elapsed_d = elapsed_q - DATA_W'(1);
          PH_CLOSE: if (elapsed_q != S16_MAX) elapsed_d = elapsed_q + DATA_W'(1);
          PH_WAITC: elapsed_d = '0;
          default:  ;
        endcase
      end
      MODE_CMD: begin
        lines_d = 2'b00;
        if (in_close) begin
          unique case (phase_q)
            PH_CLOSE: begin
              if (keep_closing) lines_d = 2'b01;
              else              phase_d = PH_WAITO;
            end
            PH_WAITO: begin
              if (!time_mode_q) begin
                if (lim_sum > (DATA_W+1)'(S16_MAX))      limit_d = S16_MAX;
                else if (lim_sum < (DATA_W+1)'(S16_MIN)) limit_d = S16_MIN;
                else                                     limit_d = lim_sum[DATA_W-1:0];
              end
            end
            default: phase_d = PH_CLOSE;   // from open or wait-close
          endcase
        end else begin
          unique case (phase_q)
            PH_OPEN: begin
              if (elapsed_q > open_lim) begin
                lines_d = 2'b10;
              end else begin
                phase_d   = PH_WAITC;
                elapsed_d = '0;
              end
            end
            PH_WAITC: ;
            default:  phase_d = PH_OPEN;   // from close or wait-open
          endcase
        end
      end
      default: ;   // samples handled by the window; unused kind ignored
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_OPEN;
      lines_q   <= 2'b00;
      elapsed_q <= '0;
      limit_q   <= '0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      lines_q   <= lines_d;
      elapsed_q <= elapsed_d;
      limit_q   <= limit_d;
    end
  end

  // ---------------- result register ----------------
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {4'd0, elapsed_d, phase_d, lines_d[1], lines_d[0]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== verif/fmoc_checker.sv =====
// Scoreboard for the finger motor open/close controller: watches the word
// streams and the APB writes, predicts each status word and compares it.
// Depends on fmoc_pkg.
`timescale 1ns / 100ps
module fmoc_checker #(
  parameter int WINDOW_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [39:0] in_data_i,
  input  logic [1:0]  in_user_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fails_o,
  output int          pending_o
);
  import fmoc_pkg::*;

  localparam int LIMIT_DIV = 4;

  typedef struct {
    logic              close_line;
    logic              open_line;
    logic [1:0]        phase;
    logic signed [15:0] elapsed;
  } status_t;

  status_t expected_status_q[$];

  // predicted controller state and registers
  logic [1:0] phase_q;
  int         elapsed_q;
  int         open_limit_q;
  int         window_mem[WINDOW_SIZE];
  int         window_total;
  int         window_idx;
  logic [1:0] lines_q;  // [0] close line, [1] open line
  int         threshold_q;
  bit         time_mode_q;

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic step_finger(input logic [1:0] kind, input logic req,
                             input logic signed [15:0] off,
                             input logic signed [15:0] smp);
    status_t s;
    int      lim;
    bit      keep;
    case (kind)
      MODE_SAMPLE: begin
        window_total = window_total - window_mem[window_idx] + smp;
        window_mem[window_idx] = smp;
        window_idx = (window_idx + 1) % WINDOW_SIZE;
      end
      MODE_TICK: begin
        case (phase_q)
          PH_OPEN:  elapsed_q = clamp16(elapsed_q - 1);
          PH_CLOSE: elapsed_q = clamp16(elapsed_q + 1);
          PH_WAITC: elapsed_q = 0;
          default:  ;
        endcase
      end
      MODE_CMD: begin
        if (req) begin
          case (phase_q)
            PH_OPEN, PH_WAITC: begin
              phase_q = PH_CLOSE;
              lines_q = 2'b00;
            end
            PH_CLOSE: begin
              keep = time_mode_q ? (elapsed_q < open_limit_q)
                                 : ((window_total / WINDOW_SIZE) < threshold_q);
              if (keep) begin
                lines_q = 2'b01;
              end else begin
                phase_q = PH_WAITO;
                lines_q = 2'b00;
              end
            end
            default: begin
              if (!time_mode_q) open_limit_q = clamp16(elapsed_q / LIMIT_DIV + off);
              lines_q = 2'b00;
            end
          endcase
        end else begin
          case (phase_q)
            PH_OPEN: begin
              lim = time_mode_q ? int'(off) : open_limit_q;
              if (elapsed_q > lim) begin
                lines_q = 2'b10;
              end else begin
                phase_q   = PH_WAITC;
                elapsed_q = 0;
                lines_q   = 2'b00;
              end
            end
            PH_WAITC: lines_q = 2'b00;
            default: begin
              phase_q = PH_OPEN;
              lines_q = 2'b00;
            end
          endcase
        end
      end
      default: ;  // unused kind: status only
    endcase
    s.close_line = lines_q[0];
    s.open_line  = lines_q[1];
    s.phase      = phase_q;
    s.elapsed    = elapsed_q[15:0];
    expected_status_q.push_back(s);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    status_t            want;
    logic signed [15:0] got_elapsed;
    if (!rst_ni) begin
      expected_status_q.delete();
      phase_q      = PH_OPEN;
      elapsed_q    = 0;
      open_limit_q = 0;
      for (int i = 0; i < WINDOW_SIZE; i++) window_mem[i] = 0;
      window_total = 0;
      window_idx   = 0;
      lines_q      = 2'b00;
      threshold_q  = 0;
      time_mode_q  = 1'b0;
      fails_o      = 0;
      pending_o    = 0;
    end else begin
      // results first: a word leaving now belongs to an earlier input
      if (out_valid_i && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          $error("status word with no prediction pending");
          fails_o++;
        end else begin
          want = expected_status_q.pop_front();
          got_elapsed = out_data_i[19:4];
          if (out_data_i[0] !== want.close_line) begin
            $error("drive_close_line: expected %0d, actual %0d", want.close_line,
                   out_data_i[0]);
            fails_o++;
          end
          if (out_data_i[1] !== want.open_line) begin
            $error("drive_open_line: expected %0d, actual %0d", want.open_line,
                   out_data_i[1]);
            fails_o++;
          end
          if (out_data_i[3:2] !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, out_data_i[3:2]);
            fails_o++;
          end
          if (got_elapsed !== want.elapsed) begin
            $error("elapsed: expected %0d, actual %0d", want.elapsed, got_elapsed);
            fails_o++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == REG_TIME_MODE) time_mode_q = pwdata_i[0];
        else threshold_q = $signed(pwdata_i[15:0]);
      end
      if (in_valid_i && in_ready_i)
        step_finger(in_user_i, in_data_i[0], in_data_i[16:1], in_data_i[32:17]);
      pending_o = expected_status_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Top of the finger motor controller bench: clock, reset, stimulus and verdict.
// Depends on fmoc_pkg, finger_motor_open_close_fsm and fmoc_checker.
`timescale 1ns / 100ps
module tb;
  import fmoc_pkg::*;

  // Slowest run: ~1.8k words, each behind the longest source idle and sink
  // stall bursts. The limit is several times what that run takes.
  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASE_WORDS = 330;
  localparam logic [1:0] MODE_UNUSED = 2'd3;  // kind the block ignores

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] close_request, [16:1] offset, [32:17] sample, [39:33] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] mode
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] drive_close_line, [1] drive_open_line, [3:2] phase, [19:4] elapsed
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr  = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fails;
  int pending;
  int cycles = 0;
  int thr_now = 0;       // threshold currently programmed, steers samples
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;

  always #5 clk_i = ~clk_i;

  finger_motor_open_close_fsm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  fmoc_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts, none once disabled.
  always begin
    @(negedge clk_i);
    if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      m_axis_tready = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    m_axis_tready = 1'b1;
  end

  // All drive tasks are entered and left at a falling edge.

  // APB write: setup cycle, then access cycle; pready is tied high.
  task automatic reg_write(input logic idx, input int value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_THRESHOLD) thr_now = $signed(pwdata[15:0]);
  endtask

  // One input word. tvalid stays high on return so back-to-back words
  // simply overwrite the data at the next falling edge.
  task automatic send_word(input logic [1:0] kind, input logic req,
                           input logic [15:0] off, input logic [15:0] smp);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = {7'b0, smp, off, req};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop sending and hold off until every predicted status word is back.
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);  // registered result, plus margin
  endtask

  task automatic program_regs(input int thr, input bit time_mode);
    drain_results();
    reg_write(REG_THRESHOLD, thr);
    reg_write(REG_TIME_MODE, int'(time_mode));
  endtask

  // Random traffic: commands, tick bursts, samples near the threshold or
  // anywhere, and a few words of the unused kind.
  task automatic random_words(input int count);
    int sent;
    int pick;
    int v;
    logic [15:0] off;
    logic [15:0] smp;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) off = 16'($urandom);
      else begin
        v   = int'($urandom_range(0, 80)) - 40;
        off = v[15:0];
      end
      if ($urandom_range(0, 1) == 0) smp = 16'($urandom);
      else begin
        v   = thr_now + int'($urandom_range(0, 64)) - 32;
        smp = v[15:0];
      end
      if (pick < 32) begin
        send_word(MODE_CMD, 1'($urandom_range(0, 1)), off, smp);
        sent++;
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(MODE_TICK, 1'($urandom_range(0, 1)), off, smp);
          sent++;
        end
      end else if (pick < 97) begin
        send_word(MODE_SAMPLE, 1'($urandom_range(0, 1)), off, smp);
        sent++;
      end else begin
        send_word(MODE_UNUSED, 1'($urandom_range(0, 1)), off, smp);
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed walk through every phase, mean mode, threshold 1.
    reg_write(REG_THRESHOLD, 1);
    reg_write(REG_TIME_MODE, 0);
    send_word(MODE_UNUSED, 1'b1, 16'hffff, 16'hffff);  // ignored, status only
    send_word(MODE_SAMPLE, 1'b0, 16'h0000, 16'h7fff);  // largest sample
    send_word(MODE_SAMPLE, 1'b0, 16'h0000, 16'h8000);  // smallest sample
    send_word(MODE_TICK,   1'b0, 16'h0000, 16'h0000);  // open counts down
    send_word(MODE_CMD,    1'b0, 16'h0000, 16'h0000);  // open below limit -> wait-close
    send_word(MODE_TICK,   1'b0, 16'h0000, 16'h0000);  // wait-close clears
    send_word(MODE_CMD,    1'b0, 16'h0000, 16'h0000);  // open in wait-close
    send_word(MODE_CMD,    1'b1, 16'h0000, 16'h0000);  // -> close
    repeat (3) send_word(MODE_TICK, 1'b0, 16'h0000, 16'h0000);  // close counts up
    send_word(MODE_CMD,    1'b1, 16'h0000, 16'h0000);  // mean 0 < 1: keep closing
    send_word(MODE_SAMPLE, 1'b0, 16'h0000, 16'h7fff);  // mean jumps well above
    send_word(MODE_CMD,    1'b1, 16'h0000, 16'h0000);  // -> wait-open
    send_word(MODE_TICK,   1'b0, 16'h0000, 16'h0000);  // wait-open holds
    send_word(MODE_CMD,    1'b1, 16'h7fff, 16'h0000);  // limit latch, max offset
    send_word(MODE_CMD,    1'b1, 16'h8000, 16'h0000);  // limit latch, min offset
    send_word(MODE_CMD,    1'b0, 16'h0000, 16'h0000);  // -> open
    send_word(MODE_CMD,    1'b0, 16'h0000, 16'h0000);  // above limit: drive open
    send_word(MODE_TICK,   1'b0, 16'h0000, 16'h0000);
    send_word(MODE_CMD,    1'b0, 16'h0000, 16'h0000);  // still driving open
    send_word(MODE_CMD,    1'b1, 16'h0000, 16'h0000);  // -> close

    // Random phases over the register space, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_regs(-32768, 1'b0);
        1: program_regs(32767, 1'b1);
        2: program_regs(int'($urandom_range(0, 65535)) - 32768, 1'b0);
        default: program_regs(int'($urandom_range(0, 400)) - 200, 1'b1);
      endcase
      random_words(PHASE_WORDS);
    end

    // Last part runs flat out: no idling on either side.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;

    // Open limit latched past both ends. Time mode with the largest offset
    // forces wait-close, which leaves elapsed at zero.
    program_regs(-32768, 1'b1);
    send_word(MODE_CMD, 1'b0, 16'h7fff, 16'h0000);  // open, or wait-close
    send_word(MODE_CMD, 1'b0, 16'h7fff, 16'h0000);  // wait-close, elapsed zero
    // Lowest threshold makes any close in close give up.
    program_regs(-32768, 1'b0);
    send_word(MODE_CMD, 1'b1, 16'h0000, 16'h0000);  // -> close
    repeat (6) send_word(MODE_TICK, 1'b0, 16'h0000, 16'h0000);  // elapsed 6
    send_word(MODE_CMD, 1'b1, 16'h0000, 16'h0000);  // -> wait-open
    send_word(MODE_CMD, 1'b1, 16'h7fff, 16'h0000);  // limit clips high
    send_word(MODE_CMD, 1'b0, 16'h0000, 16'h0000);  // -> open
    repeat (12) send_word(MODE_TICK, 1'b0, 16'h0000, 16'h0000);  // elapsed -6
    send_word(MODE_CMD, 1'b1, 16'h0000, 16'h0000);  // -> close
    send_word(MODE_CMD, 1'b1, 16'h0000, 16'h0000);  // -> wait-open
    send_word(MODE_CMD, 1'b1, 16'h8000, 16'h0000);  // limit clips low
    send_word(MODE_CMD, 1'b0, 16'h0000, 16'h0000);  // -> open
    send_word(MODE_CMD, 1'b0, 16'h0000, 16'h0000);  // above limit: drive open

    program_regs(int'($urandom_range(0, 65535)) - 32768, 1'b0);
    random_words(PHASE_WORDS);

    drain_results();
    repeat (4) @(negedge clk_i);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
